### hw/rtl/lsrc_pkg.sv
// ----------------------------------------------------------------------------
// lsrc_pkg: shared definitions for the segment clipper
// Outcode bits, segment classes, configuration register indexes, queue depth and pass limit.
// ----------------------------------------------------------------------------
`default_nettype none

package lsrc_pkg;

  localparam logic [3:0] OC_LEFT   = 4'b0001;
  localparam logic [3:0] OC_RIGHT  = 4'b0010;
  localparam logic [3:0] OC_BOTTOM = 4'b0100;
  localparam logic [3:0] OC_TOP    = 4'b1000;

  localparam int KIND_BITS = 2;

  typedef enum logic [KIND_BITS-1:0] {
    SEG_ACCEPT = 2'd0,
    SEG_REJECT = 2'd1,
    SEG_CLIP   = 2'd2
  } seg_kind_t;

  localparam int REG_IDX_BITS = 2;
  localparam logic [REG_IDX_BITS-1:0] REG_LEFT   = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_RIGHT  = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_BOTTOM = 2'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_TOP    = 2'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int PASS_BITS   = 3;
  localparam logic [PASS_BITS-1:0] PASS_LIMIT = 3'd4;

endpackage

`default_nettype wire

### hw/rtl/lsrc_if.sv
// ----------------------------------------------------------------------------
// lsrc_if: channel interfaces of the segment clipper
// Segment input, clip result and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsrc_seg_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lsrc_clip_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic                         visible;
  logic signed [COORD_BITS-1:0] clipped_start_x;
  logic signed [COORD_BITS-1:0] clipped_start_y;
  logic signed [COORD_BITS-1:0] clipped_end_x;
  logic signed [COORD_BITS-1:0] clipped_end_y;
  modport source (output valid, visible, clipped_start_x, clipped_start_y,
                  clipped_end_x, clipped_end_y, input ready);
  modport sink   (input valid, visible, clipped_start_x, clipped_start_y,
                  clipped_end_x, clipped_end_y, output ready);
endinterface

interface lsrc_cfg_if #(parameter int COORD_BITS = 16);
  logic                                 valid;
  logic                                 ready;
  logic [lsrc_pkg::REG_IDX_BITS-1:0]    idx;
  logic signed [COORD_BITS-1:0]         data;
  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/line_segment_rect_clipper.sv
// ----------------------------------------------------------------------------
// line_segment_rect_clipper: clip a line segment against a rectangle
// Outcode-based clipping with fixed point intermediate endpoints.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan   takes one segment per transaction (start and end points).
//   out_chan  gives one result per segment: visible flag and the clipped
//             endpoints, truncated toward zero; a rejected segment reads as
//             all-zero endpoints.
//   cfg_chan  writes the left, right, bottom and top edges by index; it is
//             always ready. Write only while no segment is in flight.
// Timing: a segment that is trivially accepted or rejected reaches the result
//   register from the queue once the idle sequencer takes it. Each edge
//   move runs a test state, the multiply and then the divide steps of the
//   shared multiply/divide unit and a handoff back to the test state. The
//   iterative multiply/divide unit sets how long an edge move takes; one
//   segment is worked on at a time.
// A two-entry queue splits the intake from the sequencer: intake keeps taking
//   segments while a result waits on a stalled out_chan, until the queue fills.
// Reset clears the queue, the sequencer and sets the edges to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module line_segment_rect_clipper #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  lsrc_seg_if.sink    in_chan,
  lsrc_clip_if.source out_chan,
  lsrc_cfg_if.sink    cfg_chan
);

  localparam int QW = 4 * COORD_BITS + lsrc_pkg::KIND_BITS;

  // Right and top reset to 32767, or to the largest value the width holds.
  localparam logic signed [COORD_BITS-1:0] EDGE_HI_RST =
    (COORD_BITS >= 16) ? COORD_BITS'(32767) : {1'b0, {(COORD_BITS-1){1'b1}}};

  logic signed [COORD_BITS-1:0] left_r, right_r, bottom_r, top_r;

  // Edge registers: take every write; the user writes only while the block is idle, the block does not enforce it.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      right_r  <= EDGE_HI_RST;
      bottom_r <= '0;
      top_r    <= EDGE_HI_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.idx)
        lsrc_pkg::REG_LEFT:   left_r   <= cfg_chan.data;
        lsrc_pkg::REG_RIGHT:  right_r  <= cfg_chan.data;
        lsrc_pkg::REG_BOTTOM: bottom_r <= cfg_chan.data;
        lsrc_pkg::REG_TOP:    top_r    <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  logic          q_push, q_pop, q_full, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  // Front: classify and push.
  lsrc_front #(.COORD_BITS(COORD_BITS), .QW(QW)) u_front (
    .in_chan     (in_chan),
    .left_edge   (left_r),
    .right_edge  (right_r),
    .bottom_edge (bottom_r),
    .top_edge    (top_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  // Queue: decouple intake from the clipping sequencer.
  lsrc_queue #(.WIDTH(QW), .DEPTH(lsrc_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back: edge moves and the result register.
  lsrc_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .QW(QW)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .left_edge   (left_r),
    .right_edge  (right_r),
    .bottom_edge (bottom_r),
    .top_edge    (top_r),
    .q_data      (q_rdata),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_chan    (out_chan)
  );

  // Never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push) else $error("queue push while full");

  // Never pop an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("queue pop while empty");

  // Rejected segments carry zero endpoints.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.visible) |->
      (out_chan.clipped_start_x == '0 && out_chan.clipped_start_y == '0 &&
       out_chan.clipped_end_x == '0 && out_chan.clipped_end_y == '0))
    else $error("rejected segment with nonzero endpoints");

endmodule

`default_nettype wire

### hw/rtl/lsrc_front.sv
// ----------------------------------------------------------------------------
// lsrc_front: segment intake and trivial classification
// Computes endpoint outcodes and tags each segment as accept, reject or clip.
// ----------------------------------------------------------------------------
`default_nettype none

module lsrc_front #(
  parameter int COORD_BITS = 16,
  parameter int QW         = 4 * COORD_BITS + lsrc_pkg::KIND_BITS
) (
  lsrc_seg_if.sink                     in_chan,
  input  logic signed [COORD_BITS-1:0] left_edge,
  input  logic signed [COORD_BITS-1:0] right_edge,
  input  logic signed [COORD_BITS-1:0] bottom_edge,
  input  logic signed [COORD_BITS-1:0] top_edge,
  input  logic                         q_full,
  output logic                         q_push,
  output logic [QW-1:0]                q_data
);

  // Integer compare gives the same order as the scaled compare.
  function automatic logic [3:0] outcode(input logic signed [COORD_BITS-1:0] x,
                                         input logic signed [COORD_BITS-1:0] y);
    logic [3:0] c;
    c = 4'b0000;
    if (y > top_edge)         c = lsrc_pkg::OC_TOP;
    else if (y < bottom_edge) c = lsrc_pkg::OC_BOTTOM;
    if (x > right_edge)       c = c | lsrc_pkg::OC_RIGHT;
    else if (x < left_edge)   c = c | lsrc_pkg::OC_LEFT;
    return c;
  endfunction

  logic [3:0]          c0, c1;
  lsrc_pkg::seg_kind_t kind;

  always_comb begin
    c0 = outcode(in_chan.start_x, in_chan.start_y);
    c1 = outcode(in_chan.end_x, in_chan.end_y);
    if (c0 == 4'b0000 && c1 == 4'b0000) kind = lsrc_pkg::SEG_ACCEPT;
    else if ((c0 & c1) != 4'b0000)      kind = lsrc_pkg::SEG_REJECT;
    else                                kind = lsrc_pkg::SEG_CLIP;
  end

  assign in_chan.ready = !q_full;
  assign q_push        = in_chan.valid && !q_full;
  assign q_data        = {kind, in_chan.start_x, in_chan.start_y,
                          in_chan.end_x, in_chan.end_y};

endmodule

`default_nettype wire

### hw/rtl/lsrc_queue.sv
// ----------------------------------------------------------------------------
// lsrc_queue: short register queue between front and back
// First-in first-out, one push and one pop per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lsrc_queue #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lsrc_muldiv.sv
// ----------------------------------------------------------------------------
// lsrc_muldiv: iterative (a * b) / c, truncated toward zero
// Radix-4 shift-add multiply, then two restoring divide steps per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lsrc_muldiv #(
  parameter int W = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic signed [W:0] a,
  input  logic signed [W:0] b,
  input  logic signed [W:0] c,
  output logic          done,
  output logic signed [W:0] res
);

  localparam int DH = (W + 1) / 2;
  localparam int D2 = 2 * DH;
  localparam int PW = 2 * D2;
  localparam int CW = $clog2(DH + 1);

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_t;

  md_state_t     state_r;
  logic [CW-1:0] cnt_r;
  logic [PW-1:0] ua_r, acc_r, acc_nxt;
  logic [D2-1:0] ub_r, uc_r, rem_r, lo_r, q_r, q_nxt, rem_nxt;
  logic          neg_r, zero_r, done_r;
  logic signed [W:0] res_r, res_nxt;
  logic [D2:0]   ucx, r1, r1s, r2, r2s;
  logic          ge1, ge2;

  function automatic logic [W-1:0] mag(input logic signed [W:0] v);
    logic signed [W:0] n;
    n = -v;
    return v[W] ? n[W-1:0] : v[W-1:0];
  endfunction

  always_comb begin
    acc_nxt = acc_r + (ub_r[0] ? ua_r : '0) + (ub_r[1] ? (ua_r << 1) : '0);
    ucx  = {1'b0, uc_r};
    r1   = {rem_r, lo_r[D2-1]};
    ge1  = (r1 >= ucx);
    r1s  = ge1 ? r1 - ucx : r1;
    r2   = {r1s[D2-1:0], lo_r[D2-2]};
    ge2  = (r2 >= ucx);
    r2s  = ge2 ? r2 - ucx : r2;
    rem_nxt = r2s[D2-1:0];
    q_nxt   = {q_r[D2-3:0], ge1, ge2};
    if (zero_r)     res_nxt = '0;
    else if (neg_r) res_nxt = -$signed({1'b0, q_nxt[W-1:0]});
    else            res_nxt = $signed({1'b0, q_nxt[W-1:0]});
  end

  always_ff @(posedge clk) begin
    case (state_r)
      MD_IDLE: begin
        if (start) begin
          ua_r   <= PW'(mag(a));
          ub_r   <= D2'(mag(b));
          uc_r   <= D2'(mag(c));
          acc_r  <= '0;
          neg_r  <= a[W] ^ b[W] ^ c[W];
          zero_r <= (c == '0);
        end
      end
      MD_MUL: begin
        acc_r <= acc_nxt;
        ua_r  <= ua_r << 2;
        ub_r  <= ub_r >> 2;
        rem_r <= acc_nxt[PW-1:D2];
        lo_r  <= acc_nxt[D2-1:0];
        q_r   <= '0;
      end
      MD_DIV: begin
        rem_r <= rem_nxt;
        lo_r  <= lo_r << 2;
        q_r   <= q_nxt;
        res_r <= res_nxt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        MD_IDLE: begin
          cnt_r <= '0;
          if (start) state_r <= MD_MUL;
        end
        MD_MUL: begin
          if (cnt_r == CW'(DH - 1)) begin
            cnt_r   <= '0;
            state_r <= MD_DIV;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        MD_DIV: begin
          if (cnt_r == CW'(DH - 1)) begin
            cnt_r   <= '0;
            done_r  <= 1'b1;
            state_r <= MD_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: state_r <= MD_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

`default_nettype wire

### hw/rtl/lsrc_back.sv
// ----------------------------------------------------------------------------
// lsrc_back: clipping sequencer
// Runs the edge moves of each segment, up to the pass limit, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsrc_back #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16,
  parameter int QW         = 4 * COORD_BITS + lsrc_pkg::KIND_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [COORD_BITS-1:0] left_edge,
  input  logic signed [COORD_BITS-1:0] right_edge,
  input  logic signed [COORD_BITS-1:0] bottom_edge,
  input  logic signed [COORD_BITS-1:0] top_edge,
  input  logic [QW-1:0]                q_data,
  input  logic                         q_empty,
  output logic                         q_pop,
  lsrc_clip_if.source                  out_chan
);

  localparam int W = COORD_BITS + FRAC_BITS;
  localparam int C = COORD_BITS;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_TEST = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_OUT  = 4'b1000
  } bk_state_t;

  function automatic logic signed [W-1:0] to_fix(input logic signed [C-1:0] v);
    logic signed [W-1:0] e;
    e = W'(v);
    return e <<< FRAC_BITS;
  endfunction

  function automatic logic signed [C-1:0] to_out(input logic signed [W-1:0] v);
    logic [W-1:0] m, t, r;
    m = v[W-1] ? -v : v;
    t = m >> FRAC_BITS;
    r = v[W-1] ? -t : t;
    return r[C-1:0];
  endfunction

  logic signed [W-1:0] lf, rf, bf, tf;

  function automatic logic [3:0] outcode(input logic signed [W-1:0] x,
                                         input logic signed [W-1:0] y);
    logic [3:0] c;
    c = 4'b0000;
    if (y > tf)      c = lsrc_pkg::OC_TOP;
    else if (y < bf) c = lsrc_pkg::OC_BOTTOM;
    if (x > rf)      c = c | lsrc_pkg::OC_RIGHT;
    else if (x < lf) c = c | lsrc_pkg::OC_LEFT;
    return c;
  endfunction

  bk_state_t                      state_r;
  logic [lsrc_pkg::PASS_BITS-1:0] pass_r;
  logic signed [W-1:0]            x0_r, y0_r, x1_r, y1_r, tgt_r;
  logic                           horiz_r, mov1_r;
  logic                           vis_r;
  logic signed [C-1:0]            osx_r, osy_r, oex_r, oey_r;

  lsrc_pkg::seg_kind_t kind;
  logic signed [C-1:0] qsx, qsy, qex, qey;
  logic [3:0]          c0, c1, co;
  logic                horiz, mov1, md_start, md_done;
  logic signed [W-1:0] tgt, nv, base;
  logic signed [W:0]   md_a, md_b, md_c, md_res, sum;

  assign lf = to_fix(left_edge);
  assign rf = to_fix(right_edge);
  assign bf = to_fix(bottom_edge);
  assign tf = to_fix(top_edge);

  assign kind = lsrc_pkg::seg_kind_t'(q_data[QW-1 -: lsrc_pkg::KIND_BITS]);
  assign qsx  = q_data[4*C-1 -: C];
  assign qsy  = q_data[3*C-1 -: C];
  assign qex  = q_data[2*C-1 -: C];
  assign qey  = q_data[C-1 -: C];

  always_comb begin
    c0    = outcode(x0_r, y0_r);
    c1    = outcode(x1_r, y1_r);
    mov1  = (c0 == 4'b0000);
    co    = mov1 ? c1 : c0;
    horiz = (co & (lsrc_pkg::OC_TOP | lsrc_pkg::OC_BOTTOM)) != 4'b0000;
    if ((co & lsrc_pkg::OC_TOP) != 4'b0000)         tgt = tf;
    else if ((co & lsrc_pkg::OC_BOTTOM) != 4'b0000) tgt = bf;
    else if ((co & lsrc_pkg::OC_RIGHT) != 4'b0000)  tgt = rf;
    else                                            tgt = lf;
    if (horiz) begin
      md_a = (W+1)'(x1_r) - (W+1)'(x0_r);
      md_b = (W+1)'(tgt) - (W+1)'(y0_r);
      md_c = (W+1)'(y1_r) - (W+1)'(y0_r);
    end else begin
      md_a = (W+1)'(y1_r) - (W+1)'(y0_r);
      md_b = (W+1)'(tgt) - (W+1)'(x0_r);
      md_c = (W+1)'(x1_r) - (W+1)'(x0_r);
    end
    md_start = (state_r == ST_TEST) && !(c0 == 4'b0000 && c1 == 4'b0000) &&
               ((c0 & c1) == 4'b0000) && (pass_r != lsrc_pkg::PASS_LIMIT);
    base = horiz_r ? x0_r : y0_r;
    sum  = (W+1)'(base) + md_res;
    nv   = sum[W-1:0];
  end

  lsrc_muldiv #(.W(W)) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .a     (md_a),
    .b     (md_b),
    .c     (md_c),
    .done  (md_done),
    .res   (md_res)
  );

  assign q_pop = (state_r == ST_IDLE) && !q_empty;

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          x0_r <= to_fix(qsx);
          y0_r <= to_fix(qsy);
          x1_r <= to_fix(qex);
          y1_r <= to_fix(qey);
          osx_r <= qsx;
          osy_r <= qsy;
          oex_r <= qex;
          oey_r <= qey;
          vis_r <= (kind == lsrc_pkg::SEG_ACCEPT);
          if (kind == lsrc_pkg::SEG_REJECT) begin
            osx_r <= '0;
            osy_r <= '0;
            oex_r <= '0;
            oey_r <= '0;
          end
        end
      end
      ST_TEST: begin
        horiz_r <= horiz;
        mov1_r  <= mov1;
        tgt_r   <= tgt;
        if (c0 == 4'b0000 && c1 == 4'b0000) begin
          vis_r <= 1'b1;
          osx_r <= to_out(x0_r);
          osy_r <= to_out(y0_r);
          oex_r <= to_out(x1_r);
          oey_r <= to_out(y1_r);
        end else begin
          vis_r <= 1'b0;
          osx_r <= '0;
          osy_r <= '0;
          oex_r <= '0;
          oey_r <= '0;
        end
      end
      ST_WAIT: begin
        if (md_done) begin
          if (mov1_r) begin
            x1_r <= horiz_r ? nv : tgt_r;
            y1_r <= horiz_r ? tgt_r : nv;
          end else begin
            x0_r <= horiz_r ? nv : tgt_r;
            y0_r <= horiz_r ? tgt_r : nv;
          end
        end
      end
      default: ;
    endcase
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pass_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          pass_r <= '0;
          if (!q_empty) begin
            if (kind == lsrc_pkg::SEG_ACCEPT || kind == lsrc_pkg::SEG_REJECT)
              state_r <= ST_OUT;
            else
              state_r <= ST_TEST;
          end
        end
        ST_TEST: begin
          if (md_start) state_r <= ST_WAIT;
          else          state_r <= ST_OUT;
        end
        ST_WAIT: begin
          if (md_done) begin
            pass_r  <= pass_r + 1'b1;
            state_r <= ST_TEST;
          end
        end
        ST_OUT: begin
          if (out_chan.ready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_chan.valid           = (state_r == ST_OUT);
  assign out_chan.visible         = vis_r;
  assign out_chan.clipped_start_x = osx_r;
  assign out_chan.clipped_start_y = osy_r;
  assign out_chan.clipped_end_x   = oex_r;
  assign out_chan.clipped_end_y   = oey_r;

endmodule

`default_nettype wire
